// ----- sv/cfws_pkg.sv -----
`default_nettype none

package cfws_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 16;

  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);

  // Port field widths
  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 16;
  localparam int STATUS_W = 2;
  localparam int SLOT_W   = 4;
  localparam int ENTRY_W  = 5;

  // Command queue between front and back
  localparam int QDEPTH = 2;
  localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [OPCODE_W-1:0] OP_ENQ  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_DEQ  = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_SRCH = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd3;

  typedef enum logic [1:0] {
    CMD_NOP,
    CMD_ENQ,
    CMD_DEQ,
    CMD_SRCH
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t             kind;
    logic [DATA_WIDTH-1:0] word;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_W-1:0]       status;
    logic signed [VALUE_W-1:0] out_value;
    logic [SLOT_W-1:0]         match_slot;
    logic [ENTRY_W-1:0]        entry_count;
    logic                      is_empty;
    logic                      is_full;
  } result_t;

  // Sign-extend the port word, then keep the stored width
  function automatic logic [DATA_WIDTH-1:0] to_word(input logic signed [VALUE_W-1:0] v);
    logic signed [63:0] e;
    e = 64'(v);
    return e[DATA_WIDTH-1:0];
  endfunction

  // Sign-extend a stored word back to the port width
  function automatic logic signed [VALUE_W-1:0] from_word(input logic [DATA_WIDTH-1:0] w);
    logic signed [DATA_WIDTH-1:0] s;
    logic signed [63:0]           e;
    s = w;
    e = 64'(s);
    return e[VALUE_W-1:0];
  endfunction

endpackage

`default_nettype wire

// ----- sv/cfws_in_if.sv -----
`default_nettype none

interface cfws_in_if;
  logic                               valid;
  logic                               ready;
  logic [cfws_pkg::OPCODE_W-1:0]      opcode;
  logic signed [cfws_pkg::VALUE_W-1:0] value;

  modport source (output valid, output opcode, output value, input ready);
  modport sink   (input valid, input opcode, input value, output ready);
endinterface

`default_nettype wire

// ----- sv/cfws_out_if.sv -----
`default_nettype none

interface cfws_out_if;
  logic                                valid;
  logic                                ready;
  logic [cfws_pkg::STATUS_W-1:0]       status;
  logic signed [cfws_pkg::VALUE_W-1:0] out_value;
  logic [cfws_pkg::SLOT_W-1:0]         match_slot;
  logic [cfws_pkg::ENTRY_W-1:0]        entry_count;
  logic                                is_empty;
  logic                                is_full;

  modport source (output valid, output status, output out_value, output match_slot,
                  output entry_count, output is_empty, output is_full, input ready);
  modport sink   (input valid, input status, input out_value, input match_slot,
                  input entry_count, input is_empty, input is_full, output ready);
endinterface

`default_nettype wire

// ----- sv/cfws_front.sv -----
`default_nettype none

module cfws_front (
  cfws_in_if.sink         in,
  output logic            push_valid,
  output cfws_pkg::cmd_t  push_cmd,
  input  logic            push_ready
);

  assign push_valid = in.valid;
  assign in.ready   = push_ready;

  always_comb begin
    push_cmd.word = cfws_pkg::to_word(in.value);
    unique case (in.opcode)
      cfws_pkg::OP_ENQ:  push_cmd.kind = cfws_pkg::CMD_ENQ;
      cfws_pkg::OP_DEQ:  push_cmd.kind = cfws_pkg::CMD_DEQ;
      cfws_pkg::OP_SRCH: push_cmd.kind = cfws_pkg::CMD_SRCH;
      default:           push_cmd.kind = cfws_pkg::CMD_NOP;
    endcase
  end

endmodule

`default_nettype wire

// ----- sv/cfws_cmd_q.sv -----
`default_nettype none

module cfws_cmd_q (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  input  cfws_pkg::cmd_t  push_cmd,
  output logic            push_ready,
  output logic            pop_valid,
  output cfws_pkg::cmd_t  pop_cmd,
  input  logic            pop_ready
);

  cfws_pkg::cmd_t                entries [cfws_pkg::QDEPTH];
  logic [cfws_pkg::QPTR_W-1:0]   wr_ptr;
  logic [cfws_pkg::QPTR_W-1:0]   rd_ptr;
  logic [cfws_pkg::QCNT_W-1:0]   qcnt;
  logic                          push;
  logic                          pop;

  function automatic logic [cfws_pkg::QPTR_W-1:0] ptr_inc(
      input logic [cfws_pkg::QPTR_W-1:0] p);
    return (p == cfws_pkg::QPTR_W'(cfws_pkg::QDEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign push_ready = (qcnt != cfws_pkg::QCNT_W'(cfws_pkg::QDEPTH));
  assign pop_valid  = (qcnt != '0);
  assign pop_cmd    = entries[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      qcnt   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        qcnt <= qcnt + 1'b1;
      end else if (pop && !push) begin
        qcnt <= qcnt - 1'b1;
      end
    end
  end

  a_qcnt_bound: assert property (@(posedge clk) disable iff (rst)
    qcnt <= cfws_pkg::QCNT_W'(cfws_pkg::QDEPTH))
    else $error("command queue over-filled");

endmodule

`default_nettype wire

// ----- sv/cfws_back.sv -----
`default_nettype none

module cfws_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            pop_valid,
  input  cfws_pkg::cmd_t  pop_cmd,
  output logic            pop_ready,
  cfws_out_if.source      out
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DEQ,
    S_SCAN
  } state_t;

  state_t                            state;
  logic [cfws_pkg::DATA_WIDTH-1:0]   mem [cfws_pkg::DEPTH];
  logic [cfws_pkg::DATA_WIDTH-1:0]   rd_data;
  logic [cfws_pkg::ADDR_W-1:0]       rd_addr;
  logic                              wr_en;
  logic [cfws_pkg::ADDR_W-1:0]       wr_addr;
  logic [cfws_pkg::ADDR_W-1:0]       head;
  logic [cfws_pkg::ADDR_W-1:0]       tail;
  logic [cfws_pkg::CNT_W-1:0]        cnt;
  logic [cfws_pkg::ADDR_W-1:0]       scan_ptr;
  logic [cfws_pkg::CNT_W-1:0]        scan_left;
  logic [cfws_pkg::DATA_WIDTH-1:0]   key;
  logic                              out_valid;
  logic                              out_valid_next;
  cfws_pkg::result_t                 res;
  logic                              take;
  logic                              has_room;

  function automatic logic [cfws_pkg::ADDR_W-1:0] slot_inc(
      input logic [cfws_pkg::ADDR_W-1:0] p);
    return (p == cfws_pkg::ADDR_W'(cfws_pkg::DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  function automatic cfws_pkg::result_t make_res(
      input logic [cfws_pkg::STATUS_W-1:0]       st,
      input logic signed [cfws_pkg::VALUE_W-1:0] v,
      input logic [cfws_pkg::ADDR_W-1:0]         slot,
      input logic [cfws_pkg::CNT_W-1:0]          n);
    cfws_pkg::result_t r;
    r.status      = st;
    r.out_value   = v;
    r.match_slot  = cfws_pkg::SLOT_W'(slot);
    r.entry_count = cfws_pkg::ENTRY_W'(n);
    r.is_empty    = (n == '0);
    r.is_full     = (n == cfws_pkg::CNT_W'(cfws_pkg::DEPTH));
    return r;
  endfunction

  // Take a command only while idle and once the result register is free or emptying
  assign pop_ready = (state == S_IDLE) && (!out_valid || out.ready);
  assign take      = pop_valid && pop_ready;
  assign has_room  = (cnt < cfws_pkg::CNT_W'(cfws_pkg::DEPTH));

  assign wr_en   = take && (pop_cmd.kind == cfws_pkg::CMD_ENQ) && has_room;
  assign wr_addr = (cnt == '0) ? '0 : slot_inc(tail);
  // While scanning, fetch the slot after the one being compared
  assign rd_addr = (state == S_SCAN) ? slot_inc(scan_ptr) : head;

  // Raise valid whenever a result is loaded, drop it after its transfer
  always_comb begin
    out_valid_next = out_valid && !out.ready;
    unique case (state)
      S_IDLE: begin
        if (take && !(cnt != '0 && (pop_cmd.kind == cfws_pkg::CMD_DEQ ||
                                    pop_cmd.kind == cfws_pkg::CMD_SRCH))) begin
          out_valid_next = 1'b1;
        end
      end
      S_DEQ: begin
        out_valid_next = 1'b1;
      end
      S_SCAN: begin
        if (rd_data == key || scan_left == cfws_pkg::CNT_W'(1)) begin
          out_valid_next = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= pop_cmd.word;
    end
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      head      <= '0;
      tail      <= '0;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
      unique case (state)
        S_IDLE: begin
          if (take) begin
            unique case (pop_cmd.kind)
              cfws_pkg::CMD_ENQ: begin
                if (cnt == '0) begin
                  head <= '0;
                  tail <= '0;
                  cnt  <= cfws_pkg::CNT_W'(1);
                  res  <= make_res(cfws_pkg::ST_OK, '0, '0, cfws_pkg::CNT_W'(1));
                end else if (has_room) begin
                  tail <= slot_inc(tail);
                  cnt  <= cnt + 1'b1;
                  res  <= make_res(cfws_pkg::ST_OK, '0, '0, cnt + 1'b1);
                end else begin
                  res  <= make_res(cfws_pkg::ST_FULL, '0, '0, cnt);
                end
              end
              cfws_pkg::CMD_DEQ: begin
                if (cnt == '0) begin
                  res   <= make_res(cfws_pkg::ST_EMPTY, '0, '0, cnt);
                end else begin
                  state <= S_DEQ;
                end
              end
              cfws_pkg::CMD_SRCH: begin
                if (cnt == '0) begin
                  res       <= make_res(cfws_pkg::ST_NOT_FOUND, '0, '0, cnt);
                end else begin
                  scan_ptr  <= head;
                  scan_left <= cnt;
                  key       <= pop_cmd.word;
                  state     <= S_SCAN;
                end
              end
              cfws_pkg::CMD_NOP: begin
                res <= make_res(cfws_pkg::ST_OK, '0, '0, cnt);
              end
            endcase
          end
        end
        S_DEQ: begin
          // Removing the last entry parks both pointers at slot zero
          if (cnt == cfws_pkg::CNT_W'(1)) begin
            head <= '0;
            tail <= '0;
          end else begin
            head <= slot_inc(head);
          end
          cnt   <= cnt - 1'b1;
          res   <= make_res(cfws_pkg::ST_OK, cfws_pkg::from_word(rd_data), '0,
                            cnt - 1'b1);
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (rd_data == key) begin
            res   <= make_res(cfws_pkg::ST_OK, '0, scan_ptr, cnt);
            state <= S_IDLE;
          end else if (scan_left == cfws_pkg::CNT_W'(1)) begin
            res   <= make_res(cfws_pkg::ST_NOT_FOUND, '0, '0, cnt);
            state <= S_IDLE;
          end else begin
            scan_ptr  <= slot_inc(scan_ptr);
            scan_left <= scan_left - 1'b1;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out.valid       = out_valid;
  assign out.status      = res.status;
  assign out.out_value   = res.out_value;
  assign out.match_slot  = res.match_slot;
  assign out.entry_count = res.entry_count;
  assign out.is_empty    = res.is_empty;
  assign out.is_full     = res.is_full;

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= cfws_pkg::CNT_W'(cfws_pkg::DEPTH))
    else $error("entry count beyond depth");

  a_empty_parked: assert property (@(posedge clk) disable iff (rst)
    (cnt == '0) |-> (head == '0 && tail == '0))
    else $error("pointers not parked while empty");

  a_busy_no_result: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> !out_valid)
    else $error("result pending while a command is in flight");

  a_scan_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN) |-> (cnt != '0 && scan_left != '0 && scan_left <= cnt))
    else $error("scan running over an empty or short queue");

endmodule

`default_nettype wire

// ----- sv/circular_fifo_with_search.sv -----
// Each command passes through the two-entry command queue to the back end, which registers its result.
// Enqueues and ignored opcodes are taken at one per cycle while the output is being taken; a dequeue
// goes through the S_DEQ state, and a search walks the held entries from the head until the first match,
// over the single slot read port, so the back end takes no new command until either is through.
// A two-entry command queue keeps taking input while the back end works.
// Reset (rst, synchronous) empties the queue and parks the pointers; slot storage is not cleared.
`default_nettype none

module circular_fifo_with_search (
  input  logic       clk,
  input  logic       rst,
  cfws_in_if.sink    in,
  cfws_out_if.source out
);

  logic            push_valid;
  logic            push_ready;
  cfws_pkg::cmd_t  push_cmd;
  logic            pop_valid;
  logic            pop_ready;
  cfws_pkg::cmd_t  pop_cmd;

  cfws_front u_front (
    .in         (in),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready)
  );

  cfws_cmd_q u_cmd_q (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop_ready  (pop_ready)
  );

  cfws_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop_cmd   (pop_cmd),
    .pop_ready (pop_ready),
    .out       (out)
  );

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
`default_nettype none

module tb_top;

  localparam logic [cfws_pkg::OPCODE_W-1:0] OP_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_PER_PHASE = 267;
  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic [cfws_pkg::OPCODE_W-1:0]       opcode;
    logic signed [cfws_pkg::VALUE_W-1:0] value;
  } fifo_cmd_t;

  logic clk = 1'b0;
  logic rst;

  cfws_in_if  in_ch ();
  cfws_out_if out_ch ();

  circular_fifo_with_search dut (
    .clk (clk),
    .rst (rst),
    .in  (in_ch),
    .out (out_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the queue contents, advanced on every input transfer
  logic [cfws_pkg::DATA_WIDTH-1:0] shadow_slots [cfws_pkg::DEPTH];
  logic [cfws_pkg::ADDR_W-1:0]     shadow_head;
  logic [cfws_pkg::ADDR_W-1:0]     shadow_tail;
  logic                            shadow_empty;

  fifo_cmd_t         cmd_backlog [$];
  cfws_pkg::result_t expected_results [$];

  int  n_queued;
  int  n_accepted;
  int  mismatches;
  int  cycles;
  int  send_idle_pct;
  int  recv_idle_pct;
  logic in_took;

  logic signed [cfws_pkg::VALUE_W-1:0] value_pool [8];

  function automatic int held_count();
    if (shadow_empty)
      return 0;
    return ((int'(shadow_tail) + cfws_pkg::DEPTH - int'(shadow_head)) % cfws_pkg::DEPTH) + 1;
  endfunction

  function automatic cfws_pkg::result_t predict_fifo(
      input logic [cfws_pkg::OPCODE_W-1:0]       op,
      input logic signed [cfws_pkg::VALUE_W-1:0] val);
    cfws_pkg::result_t               r;
    logic [cfws_pkg::DATA_WIDTH-1:0] w;
    int                              held;
    int                              s;
    r    = '0;
    w    = cfws_pkg::DATA_WIDTH'(val);
    held = held_count();
    case (op)
      cfws_pkg::OP_ENQ: begin
        if (shadow_empty) begin
          shadow_head     = '0;
          shadow_tail     = '0;
          shadow_slots[0] = w;
          shadow_empty    = 1'b0;
        end else if (held < cfws_pkg::DEPTH) begin
          shadow_tail = cfws_pkg::ADDR_W'((int'(shadow_tail) + 1) % cfws_pkg::DEPTH);
          shadow_slots[shadow_tail] = w;
        end else begin
          r.status = cfws_pkg::ST_FULL;
        end
      end
      cfws_pkg::OP_DEQ: begin
        if (shadow_empty) begin
          r.status = cfws_pkg::ST_EMPTY;
        end else begin
          r.out_value = cfws_pkg::VALUE_W'($signed(shadow_slots[shadow_head]));
          // last entry out: park both pointers at slot zero
          if (shadow_head == shadow_tail) begin
            shadow_empty = 1'b1;
            shadow_head  = '0;
            shadow_tail  = '0;
          end else begin
            shadow_head = cfws_pkg::ADDR_W'((int'(shadow_head) + 1) % cfws_pkg::DEPTH);
          end
        end
      end
      cfws_pkg::OP_SRCH: begin
        r.status = cfws_pkg::ST_NOT_FOUND;
        for (int i = 0; i < held; i++) begin
          s = (int'(shadow_head) + i) % cfws_pkg::DEPTH;
          if (shadow_slots[s] == w) begin
            r.status     = cfws_pkg::ST_OK;
            r.match_slot = cfws_pkg::SLOT_W'(s);
            break;
          end
        end
      end
      default: ;
    endcase
    held          = held_count();
    r.entry_count = cfws_pkg::ENTRY_W'(held);
    r.is_empty    = (held == 0);
    r.is_full     = (held == cfws_pkg::DEPTH);
    return r;
  endfunction

  task automatic push_cmd(input logic [cfws_pkg::OPCODE_W-1:0]       op,
                          input logic signed [cfws_pkg::VALUE_W-1:0] val);
    fifo_cmd_t c;
    c.opcode = op;
    c.value  = val;
    cmd_backlog.push_back(c);
    n_queued++;
  endtask

  task automatic queue_random(input int n);
    logic fill_bias;
    int   r;
    logic [cfws_pkg::OPCODE_W-1:0]       op;
    logic signed [cfws_pkg::VALUE_W-1:0] val;
    fill_bias = 1'b1;
    for (int k = 0; k < n; k++) begin
      // swing between filling and draining so the queue wraps and empties often
      if ($urandom_range(0, 19) == 0)
        fill_bias = ~fill_bias;
      r = $urandom_range(0, 99);
      if (r < 3)
        op = OP_IGNORED;
      else if (r < 28)
        op = cfws_pkg::OP_SRCH;
      else if ($urandom_range(0, 99) < (fill_bias ? 75 : 25))
        op = cfws_pkg::OP_ENQ;
      else
        op = cfws_pkg::OP_DEQ;
      if ($urandom_range(0, 99) < 70)
        val = value_pool[$urandom_range(0, 7)];
      else
        val = cfws_pkg::VALUE_W'($urandom());
      push_cmd(op, val);
    end
  endtask

  task automatic wait_drained();
    while (n_accepted != n_queued || expected_results.size() != 0)
      @(negedge clk);
  endtask

  // Driver: hold valid until the transfer, then fetch the next command
  always @(negedge clk) begin : driver
    fifo_cmd_t nxt;
    logic      next_valid;
    next_valid = in_ch.valid;
    if (in_took)
      next_valid = 1'b0;
    in_took = 1'b0;
    if (!rst && !next_valid && cmd_backlog.size() != 0 &&
        $urandom_range(0, 99) >= send_idle_pct) begin
      nxt = cmd_backlog.pop_front();
      in_ch.opcode <= nxt.opcode;
      in_ch.value  <= nxt.value;
      next_valid = 1'b1;
    end
    in_ch.valid  <= next_valid;
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // Monitor: check results against the oldest expectation, record input transfers
  always @(posedge clk) begin : monitor
    cfws_pkg::result_t want;
    cfws_pkg::result_t got;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("DONE: errors detected");
      $finish;
    end else if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        got.status      = out_ch.status;
        got.out_value   = out_ch.out_value;
        got.match_slot  = out_ch.match_slot;
        got.entry_count = out_ch.entry_count;
        got.is_empty    = out_ch.is_empty;
        got.is_full     = out_ch.is_full;
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("cycle %0d: result with nothing expected: status=%0d value=%0d",
                     cycles, got.status, got.out_value);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status || got.out_value !== want.out_value ||
              got.match_slot !== want.match_slot || got.entry_count !== want.entry_count ||
              got.is_empty !== want.is_empty || got.is_full !== want.is_full) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
              $display("cycle %0d: mismatch exp st=%0d val=%0d slot=%0d cnt=%0d e=%0b f=%0b",
                       cycles, want.status, want.out_value, want.match_slot,
                       want.entry_count, want.is_empty, want.is_full,
                       " got st=%0d val=%0d slot=%0d cnt=%0d e=%0b f=%0b",
                       got.status, got.out_value, got.match_slot,
                       got.entry_count, got.is_empty, got.is_full);
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        expected_results.push_back(predict_fifo(in_ch.opcode, in_ch.value));
        n_accepted++;
        in_took = 1'b1;
      end
    end
  end

  initial begin
    rst           = 1'b1;
    in_ch.valid   = 1'b0;
    in_ch.opcode  = '0;
    in_ch.value   = '0;
    out_ch.ready  = 1'b0;
    in_took       = 1'b0;
    shadow_head   = '0;
    shadow_tail   = '0;
    shadow_empty  = 1'b1;
    n_queued      = 0;
    n_accepted    = 0;
    mismatches    = 0;
    cycles        = 0;
    send_idle_pct = 22;
    recv_idle_pct = 48;

    value_pool[0] = 16'sh8000;
    value_pool[1] = 16'sh7fff;
    value_pool[2] = '0;
    value_pool[3] = -16'sd1;
    for (int k = 4; k < 8; k++)
      value_pool[k] = cfws_pkg::VALUE_W'($urandom());

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: empty-queue corner cases
    push_cmd(cfws_pkg::OP_SRCH, 16'sd0);
    push_cmd(cfws_pkg::OP_DEQ, 16'sd0);
    push_cmd(OP_IGNORED, 16'sh5a5a);
    // single entry in and out again: pointers return to slot zero
    push_cmd(cfws_pkg::OP_ENQ, 16'sh7fff);
    push_cmd(cfws_pkg::OP_DEQ, 16'sd0);
    push_cmd(cfws_pkg::OP_ENQ, 16'sh8000);
    push_cmd(cfws_pkg::OP_ENQ, 16'sd0);
    push_cmd(cfws_pkg::OP_ENQ, -16'sd1);
    push_cmd(cfws_pkg::OP_ENQ, 16'sd1);
    push_cmd(cfws_pkg::OP_SRCH, -16'sd1);
    push_cmd(cfws_pkg::OP_SRCH, 16'sd12345);
    push_cmd(cfws_pkg::OP_DEQ, 16'sd0);
    // fill to the brim so the tail wraps, then overflow and search across the wrap
    for (int k = 0; k < 13; k++)
      push_cmd(cfws_pkg::OP_ENQ, cfws_pkg::VALUE_W'(1000 + k));
    push_cmd(cfws_pkg::OP_ENQ, 16'sd7);
    push_cmd(cfws_pkg::OP_SRCH, 16'sd1012);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          send_idle_pct = 22;
          recv_idle_pct = 48;
        end
        1: begin
          send_idle_pct = 48;
          recv_idle_pct = 22;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      queue_random(RANDOM_PER_PHASE);
      // sender holds off here until every outstanding result is back
      wait_drained();
    end

    repeat (cfws_pkg::DEPTH + 8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

endmodule

`default_nettype wire
